// ===== hdl/mrvt_pkg.sv =====
package mrvt_pkg;

  localparam int ID_W   = 64;
  localparam int RATE_W = 10;
  localparam int PID_W  = 32;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VOTE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [RATE_W-1:0] rate;
  } ev_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic emit_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_last;
    logic [1:0] ev_cnt;
  } sts_t;

endpackage

// ===== hdl/mrvt_ctrl.sv =====
module mrvt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mrvt_pkg::cmd_t cmd,
  input  mrvt_pkg::sts_t sts
);
  import mrvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_sel_r, emit_sel_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load     = in_valid && in_ready;
  assign cmd.scan     = (state_r == S_SCAN);
  assign cmd.decide   = (state_r == S_DECIDE);
  assign cmd.emit_sel = emit_sel_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    emit_sel_nxt  = emit_sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        // ev_cnt already reflects this item's decision
        if (sts.ev_cnt != 2'd0) begin
          state_nxt     = S_EMIT;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (!emit_sel_r && sts.ev_cnt == 2'd2) begin
            emit_sel_nxt = 1'b1;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b0;
            emit_sel_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
        emit_sel_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      emit_sel_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      emit_sel_r  <= emit_sel_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input taken while a result is pending");

  a_emit_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DECIDE))
    else $error("result raised outside of decision");

  a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && emit_sel_r |=> !out_valid_r)
    else $error("more than two results for one item");
`endif

endmodule

// ===== hdl/mrvt_dpath.sv =====
module mrvt_dpath #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PID_SHIFT     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mrvt_pkg::ID_W-1:0]        in_surface_id,
  input  logic [mrvt_pkg::RATE_W-1:0]      in_rate_hz,
  input  mrvt_pkg::cmd_t                   cmd,
  output mrvt_pkg::sts_t                   sts,
  output logic [mrvt_pkg::KIND_W-1:0]      out_kind,
  output logic [mrvt_pkg::PID_W-1:0]       out_pid,
  output logic [mrvt_pkg::RATE_W-1:0]      out_rate,
  output logic                             out_last
);
  import mrvt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = ID_W + RATE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // table storage: one write port, one registered read port
  logic [EW-1:0] mem_r [TABLE_ENTRIES];
  logic [EW-1:0] rd_data_r;
  logic          mem_we;
  logic [IW-1:0] wr_idx;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [ID_W-1:0]   id_r;
  logic [RATE_W-1:0] rate_r;

  logic [IW-1:0] addr_r, addr_nxt;
  logic          rd_pend_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;

  logic              hit_f_r, hit_f_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic              free_f_r, free_f_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic              best_f_r, best_f_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [RATE_W-1:0] best_rate_r, best_rate_nxt;

  logic [PID_W-1:0]  last_pid_r, last_pid_nxt;
  logic [RATE_W-1:0] last_rate_r, last_rate_nxt;
  logic              vote_active_r, vote_active_nxt;

  logic [1:0] ev_cnt_r, ev_cnt_nxt;
  ev_t        ev0_r, ev0_nxt;
  ev_t        ev1_r, ev1_nxt;

  logic [ID_W-1:0]   rd_id;
  logic [RATE_W-1:0] rd_rate;
  logic              rd_better;

  logic              present, full, cand_wins, any_entry;
  logic [ID_W-1:0]   win_id, win_sh;
  logic [RATE_W-1:0] win_rate;
  logic [PID_W-1:0]  win_pid;
  logic              old_pos, new_pos, cancel_on;

  assign rd_id   = rd_data_r[EW-1:RATE_W];
  assign rd_rate = rd_data_r[RATE_W-1:0];
  assign rd_better = !best_f_r || (rd_rate > best_rate_r) ||
                     (rd_rate == best_rate_r && rd_id < best_id_r);

  // decision terms; the incoming item competes against the scanned best
  assign present   = (rate_r != '0);
  assign full      = present && !hit_f_r && !free_f_r;
  assign cand_wins = present && (!best_f_r || (rate_r > best_rate_r) ||
                     (rate_r == best_rate_r && id_r < best_id_r));
  assign any_entry = present || best_f_r;
  assign win_id    = cand_wins ? id_r : best_id_r;
  assign win_rate  = cand_wins ? rate_r : best_rate_r;
  assign win_sh    = win_id >> PID_SHIFT;
  assign win_pid   = win_sh[PID_W-1:0];
  assign old_pos   = !last_pid_r[PID_W-1] && (last_pid_r != '0);
  assign new_pos   = !win_pid[PID_W-1] && (win_pid != '0);
  assign cancel_on = vote_active_r && old_pos;

  assign mem_we = cmd.decide && present && (hit_f_r || free_f_r);
  assign wr_idx = hit_f_r ? hit_idx_r : free_idx_r;

  always_comb begin
    addr_nxt        = addr_r;
    hit_f_nxt       = hit_f_r;
    hit_idx_nxt     = hit_idx_r;
    free_f_nxt      = free_f_r;
    free_idx_nxt    = free_idx_r;
    best_f_nxt      = best_f_r;
    best_id_nxt     = best_id_r;
    best_rate_nxt   = best_rate_r;
    valid_nxt       = valid_r;
    last_pid_nxt    = last_pid_r;
    last_rate_nxt   = last_rate_r;
    vote_active_nxt = vote_active_r;
    ev_cnt_nxt      = ev_cnt_r;
    ev0_nxt         = ev0_r;
    ev1_nxt         = ev1_r;

    if (cmd.load) begin
      addr_nxt   = '0;
      hit_f_nxt  = 1'b0;
      free_f_nxt = 1'b0;
      best_f_nxt = 1'b0;
    end
    if (cmd.scan) addr_nxt = addr_r + IW'(1);

    if (rd_pend_r) begin
      if (rd_vld_r) begin
        if (rd_id == id_r) begin
          hit_f_nxt   = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end else if (rd_better) begin
          best_f_nxt    = 1'b1;
          best_id_nxt   = rd_id;
          best_rate_nxt = rd_rate;
        end
      end else if (!free_f_r) begin
        free_f_nxt   = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
    end

    if (cmd.decide) begin
      ev_cnt_nxt = 2'd0;
      if (full) begin
        ev0_nxt    = '{kind: KIND_FULL, pid: '0, rate: '0};
        ev_cnt_nxt = 2'd1;
      end else begin
        if (!present) begin
          if (hit_f_r) valid_nxt[hit_idx_r] = 1'b0;
        end else if (!hit_f_r) begin
          valid_nxt[free_idx_r] = 1'b1;
        end

        if (!any_entry) begin
          if (cancel_on) begin
            ev0_nxt    = '{kind: KIND_CANCEL, pid: last_pid_r, rate: '0};
            ev_cnt_nxt = 2'd1;
          end
          vote_active_nxt = 1'b0;
          last_pid_nxt    = '0;
          last_rate_nxt   = '0;
        end else if (!(win_rate == last_rate_r && win_pid == last_pid_r)) begin
          if (cancel_on) begin
            ev0_nxt = '{kind: KIND_CANCEL, pid: last_pid_r, rate: '0};
          end
          if (new_pos) begin
            if (cancel_on) ev1_nxt = '{kind: KIND_VOTE, pid: win_pid, rate: win_rate};
            else           ev0_nxt = '{kind: KIND_VOTE, pid: win_pid, rate: win_rate};
          end
          ev_cnt_nxt      = {1'b0, cancel_on} + {1'b0, new_pos};
          vote_active_nxt = 1'b1;
          last_pid_nxt    = win_pid;
          last_rate_nxt   = win_rate;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[wr_idx] <= {id_r, rate_r};
    rd_data_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_surface_id;
      rate_r <= in_rate_hz;
    end
    rd_idx_r    <= addr_r;
    rd_vld_r    <= valid_r[addr_r];
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_rate_r <= best_rate_nxt;
    ev0_r       <= ev0_nxt;
    ev1_r       <= ev1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r        <= '0;
      rd_pend_r     <= 1'b0;
      hit_f_r       <= 1'b0;
      free_f_r      <= 1'b0;
      best_f_r      <= 1'b0;
      valid_r       <= '0;
      last_pid_r    <= '0;
      last_rate_r   <= '0;
      vote_active_r <= 1'b0;
      ev_cnt_r      <= 2'd0;
    end else begin
      addr_r        <= addr_nxt;
      rd_pend_r     <= cmd.scan;
      hit_f_r       <= hit_f_nxt;
      free_f_r      <= free_f_nxt;
      best_f_r      <= best_f_nxt;
      valid_r       <= valid_nxt;
      last_pid_r    <= last_pid_nxt;
      last_rate_r   <= last_rate_nxt;
      vote_active_r <= vote_active_nxt;
      ev_cnt_r      <= ev_cnt_nxt;
    end
  end

  assign sts.scan_last = (addr_r == LAST_IDX);
  assign sts.ev_cnt    = ev_cnt_nxt;

  assign out_kind = cmd.emit_sel ? ev1_r.kind : ev0_r.kind;
  assign out_pid  = cmd.emit_sel ? ev1_r.pid  : ev0_r.pid;
  assign out_rate = cmd.emit_sel ? ev1_r.rate : ev0_r.rate;
  assign out_last = cmd.emit_sel || (ev_cnt_r == 2'd1);

`ifndef NO_ASSERTIONS
  a_idle_vote_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !vote_active_r |-> (last_pid_r == '0 && last_rate_r == '0))
    else $error("last vote kept without an active vote");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r == 2'd2 |-> (ev0_r.kind == KIND_CANCEL && ev1_r.kind == KIND_VOTE))
    else $error("two results that are not cancel then vote");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !cmd.decide)
    else $error("decision before the scan drained");
`endif

endmodule

// ===== hdl/max_rate_vote_table.sv =====
// Refresh-rate vote table. Each input item sets the rate requested by one
// source id (rate 0 removes it) in a table of TABLE_ENTRIES entries; the block
// then picks the highest rate, smallest id on ties, and when the winner
// changes emits a cancel of the old vote and a vote for the process id held in
// bits [PID_SHIFT+31:PID_SHIFT] of the winning id. Events for a process id of
// 0 or below are suppressed; an insert into a full table yields one table-full
// item. Every input item gives zero to two result items, the final one marked
// by out_last_event. One item is handled at a time: after acceptance the
// table memory is scanned one entry per cycle through its single read port,
// followed by a drain state and a decision state, then result items are given
// one per cycle while out_ready is high. No clearing pass is needed after reset.
module max_rate_vote_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PID_SHIFT     = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrvt_pkg::ID_W-1:0]   in_surface_id,
  input  logic [mrvt_pkg::RATE_W-1:0] in_rate_hz,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mrvt_pkg::KIND_W-1:0] out_event_kind,
  output logic signed [mrvt_pkg::PID_W-1:0] out_process_id,
  output logic [mrvt_pkg::RATE_W-1:0] out_voted_rate,
  output logic                        out_last_event
);
  import mrvt_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [PID_W-1:0] pid;

  mrvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mrvt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PID_SHIFT     (PID_SHIFT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_surface_id (in_surface_id),
    .in_rate_hz    (in_rate_hz),
    .cmd           (cmd),
    .sts           (sts),
    .out_kind      (out_event_kind),
    .out_pid       (pid),
    .out_rate      (out_voted_rate),
    .out_last      (out_last_event)
  );

  assign out_process_id = $signed(pid);

endmodule
